>>> rtl/core/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the uv sphere triangle index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

    localparam int IDX_W       = 20;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STACK_COUNT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] SLICE_COUNT_RESET = 11'd16;
    localparam logic [CFG_DATA_W-1:0] STACK_COUNT_RESET = 11'd8;

    // first vertex of the first ring, just after the top pole
    localparam logic [IDX_W-1:0] FIRST_RING_OFFSET = 20'd1;

    typedef enum logic [1:0] {
        BAND_TOP = 2'd0,
        BAND_MID = 2'd1,
        BAND_BOT = 2'd2
    } band_t;

    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic [IDX_W-1:0] third;
        band_t            band;
        logic             last;
    } triangle_t;

endpackage

`default_nettype wire

>>> rtl/core/uv_sphere_index_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_index_generator
// Triangle index list of a uv sphere, one triangle for each input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid / in_ready / restart): each transfer asks for
//   one triangle; restart = 1 sends the walk back to the first top-fan
//   triangle before that triangle is formed.
//   output channel (out_valid / out_ready): one triangle per input transfer,
//   in order, with three vertex indices, the band and a last-triangle flag.
//   configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   index 0 slice count, index 1 stack count; always ready, write only
//   while no triangle is in flight.
// Pipeline: a triangle passes the input register, then the result register,
//   on its way from the input transfer to the output channel.
// Throughput: one triangle per cycle while out_ready is high; the adders and
//   the one pole multiply form it between the input and the result register.
// Reset: counts return to 16 slices and 8 stacks, the walk to the top fan.
// Stall: while out_ready is low the result holds; the input register keeps
//   taking one more transfer, then in_ready falls until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_index_generator #(
    parameter int MAX_SLICES = 1024,
    parameter int MAX_STACKS = 1024
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               restart,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [uvs_pkg::IDX_W-1:0]               index_first,
    output logic [uvs_pkg::IDX_W-1:0]               index_second,
    output logic [uvs_pkg::IDX_W-1:0]               index_third,
    output logic [1:0]                              band,
    output logic                                    last_triangle,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [uvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [uvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import uvs_pkg::*;

    localparam int SW = $clog2(MAX_SLICES + 1);
    localparam int TW = $clog2(MAX_STACKS + 1);

    logic [SW-1:0] slices;
    logic [TW-1:0] stacks;

    logic      s1_valid_reg;
    logic      s1_restart_reg;
    logic      out_valid_reg;
    triangle_t triangle_reg;
    triangle_t triangle;
    logic      out_load;
    logic      s1_move;
    logic      in_fire;

    uvs_cfg #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_STACKS (MAX_STACKS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .slices    (slices),
        .stacks    (stacks)
    );

    uvs_walker #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_STACKS (MAX_STACKS)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (s1_move),
        .restart  (s1_restart_reg),
        .slices   (slices),
        .stacks   (stacks),
        .triangle (triangle)
    );

    assign out_load = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || out_load;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_restart_reg <= restart;
        end
        if (s1_move)
        begin
            triangle_reg <= triangle;
        end
    end

    assign out_valid     = out_valid_reg;
    assign index_first   = triangle_reg.first;
    assign index_second  = triangle_reg.second;
    assign index_third   = triangle_reg.third;
    assign band          = triangle_reg.band;
    assign last_triangle = triangle_reg.last;

`ifndef ASSERT_OFF
    // an input transfer always lands in the input register
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("input transfer lost");

    // a blocked input item stays put with its restart bit
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_restart_reg))
        else $error("stalled input item dropped or changed");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated after transfer");
`endif

endmodule

`default_nettype wire

>>> rtl/core/uvs_cfg.sv
// ----------------------------------------------------------------------------
// uvs_cfg
// Slice and stack count registers, clamped to their usable ranges.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cfg #(
    parameter int MAX_SLICES = 1024,
    parameter int MAX_STACKS = 1024,
    localparam int SW = $clog2(MAX_SLICES + 1),
    localparam int TW = $clog2(MAX_STACKS + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [uvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [uvs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [SW-1:0]                           slices,
    output logic [TW-1:0]                           stacks
);
    import uvs_pkg::*;

    localparam logic [31:0] MAX_S = 32'(MAX_SLICES);
    localparam logic [31:0] MAX_T = 32'(MAX_STACKS);

    logic [CFG_DATA_W-1:0] slice_count_reg;
    logic [CFG_DATA_W-1:0] stack_count_reg;
    logic [31:0]           slice_wide;
    logic [31:0]           stack_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= SLICE_COUNT_RESET;
            stack_count_reg <= STACK_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_SLICE_COUNT)
            begin
                slice_count_reg <= cfg_data;
            end
            else if (cfg_index == REG_STACK_COUNT)
            begin
                stack_count_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        slice_wide = 32'(slice_count_reg);
        stack_wide = 32'(stack_count_reg);
        if (slice_wide < 32'd1)
        begin
            slice_wide = 32'd1;
        end
        else if (slice_wide > MAX_S)
        begin
            slice_wide = MAX_S;
        end
        if (stack_wide < 32'd2)
        begin
            stack_wide = 32'd2;
        end
        else if (stack_wide > MAX_T)
        begin
            stack_wide = MAX_T;
        end
    end

    assign slices = SW'(slice_wide);
    assign stacks = TW'(stack_wide);

endmodule

`default_nettype wire

>>> rtl/core/uvs_walker.sv
// ----------------------------------------------------------------------------
// uvs_walker
// Band, ring and slice counters with the triangle formed from them.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_walker #(
    parameter int MAX_SLICES = 1024,
    parameter int MAX_STACKS = 1024,
    localparam int SW = $clog2(MAX_SLICES + 1),
    localparam int TW = $clog2(MAX_STACKS + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic               restart,
    input  wire logic [SW-1:0]      slices,
    input  wire logic [TW-1:0]      stacks,
    output uvs_pkg::triangle_t      triangle
);
    import uvs_pkg::*;

    localparam int CW  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int RW  = $clog2(MAX_STACKS);
    localparam int SCW = ((CW > SW) ? CW : SW) + 1;
    localparam int RCW = ((RW > TW) ? RW : TW) + 2;
    localparam int PW  = SW + TW;

    band_t            band_reg,   band_next;
    logic [RW-1:0]    ring_reg,   ring_next;
    logic [CW-1:0]    slice_reg,  slice_next;
    logic             half_reg,   half_next;
    logic [IDX_W-1:0] offset_reg, offset_next;

    band_t            cur_band;
    logic [RW-1:0]    cur_ring;
    logic [CW-1:0]    cur_slice;
    logic             cur_half;
    logic [IDX_W-1:0] cur_offset;

    logic             last_slice;
    logic             last_ring;
    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] s_idx;
    logic [IDX_W-1:0] two_s_m1;
    logic [PW-1:0]    pole_product;
    logic [IDX_W-1:0] bottom_pole;

    // restart takes effect before the triangle is formed
    always_comb
    begin
        if (restart)
        begin
            cur_band   = BAND_TOP;
            cur_ring   = '0;
            cur_slice  = '0;
            cur_half   = 1'b0;
            cur_offset = FIRST_RING_OFFSET;
        end
        else
        begin
            cur_band   = band_reg;
            cur_ring   = ring_reg;
            cur_slice  = slice_reg;
            cur_half   = half_reg;
            cur_offset = offset_reg;
        end
    end

    // counters left over from a larger setting count as the last one
    assign last_slice   = (SCW'(cur_slice) + SCW'(1)) >= SCW'(slices);
    assign last_ring    = (RCW'(cur_ring) + RCW'(3)) >= RCW'(stacks);
    assign j_idx        = IDX_W'(cur_slice);
    assign s_idx        = IDX_W'(slices);
    assign two_s_m1     = (s_idx << 1) - IDX_W'(1);
    assign pole_product = PW'(slices) * PW'(stacks - TW'(1));
    assign bottom_pole  = IDX_W'(pole_product) + IDX_W'(1);

    // next state
    always_comb
    begin
        band_next   = cur_band;
        ring_next   = cur_ring;
        slice_next  = cur_slice;
        half_next   = cur_half;
        offset_next = cur_offset;
        unique case (cur_band)
            BAND_MID:
            begin
                if (!cur_half)
                begin
                    half_next = 1'b1;
                end
                else
                begin
                    half_next = 1'b0;
                    if (!last_slice)
                    begin
                        slice_next = cur_slice + CW'(1);
                    end
                    else
                    begin
                        slice_next  = '0;
                        offset_next = cur_offset + s_idx;
                        if (last_ring)
                        begin
                            band_next = BAND_BOT;
                        end
                        else
                        begin
                            ring_next = cur_ring + RW'(1);
                        end
                    end
                end
            end
            BAND_BOT:
            begin
                if (!last_slice)
                begin
                    slice_next = cur_slice + CW'(1);
                end
                else
                begin
                    band_next   = BAND_TOP;
                    ring_next   = '0;
                    slice_next  = '0;
                    half_next   = 1'b0;
                    offset_next = FIRST_RING_OFFSET;
                end
            end
            default:
            begin
                if (!last_slice)
                begin
                    slice_next = cur_slice + CW'(1);
                end
                else
                begin
                    slice_next  = '0;
                    ring_next   = '0;
                    half_next   = 1'b0;
                    offset_next = FIRST_RING_OFFSET;
                    // two stacks leave the middle band empty
                    band_next   = (stacks == TW'(2)) ? BAND_BOT : BAND_MID;
                end
            end
        endcase
    end

    // triangle outputs
    always_comb
    begin
        triangle.last = 1'b0;
        unique case (cur_band)
            BAND_MID:
            begin
                triangle.band = BAND_MID;
                if (!cur_half)
                begin
                    if (!last_slice)
                    begin
                        triangle.first  = cur_offset + j_idx + s_idx;
                        triangle.second = cur_offset + j_idx;
                        triangle.third  = cur_offset + j_idx + IDX_W'(1);
                    end
                    else
                    begin
                        triangle.first  = cur_offset + s_idx;
                        triangle.second = cur_offset + two_s_m1;
                        triangle.third  = cur_offset;
                    end
                end
                else
                begin
                    if (!last_slice)
                    begin
                        triangle.first  = cur_offset + j_idx + s_idx;
                        triangle.second = cur_offset + j_idx + IDX_W'(1);
                        triangle.third  = cur_offset + j_idx + s_idx + IDX_W'(1);
                    end
                    else
                    begin
                        triangle.first  = cur_offset;
                        triangle.second = cur_offset + two_s_m1;
                        triangle.third  = cur_offset + s_idx - IDX_W'(1);
                    end
                end
            end
            BAND_BOT:
            begin
                triangle.band  = BAND_BOT;
                triangle.third = bottom_pole;
                if (!last_slice)
                begin
                    triangle.first  = cur_offset + j_idx;
                    triangle.second = cur_offset + j_idx + IDX_W'(1);
                end
                else
                begin
                    triangle.first  = cur_offset + s_idx - IDX_W'(1);
                    triangle.second = cur_offset;
                    triangle.last   = 1'b1;
                end
            end
            default:
            begin
                triangle.band  = BAND_TOP;
                triangle.third = '0;
                if (!last_slice)
                begin
                    triangle.first  = j_idx + IDX_W'(2);
                    triangle.second = j_idx + IDX_W'(1);
                end
                else
                begin
                    triangle.first  = FIRST_RING_OFFSET;
                    triangle.second = s_idx;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= BAND_TOP;
            ring_reg   <= '0;
            slice_reg  <= '0;
            half_reg   <= 1'b0;
            offset_reg <= FIRST_RING_OFFSET;
        end
        else if (advance)
        begin
            band_reg   <= band_next;
            ring_reg   <= ring_next;
            slice_reg  <= slice_next;
            half_reg   <= half_next;
            offset_reg <= offset_next;
        end
    end

`ifndef ASSERT_OFF
    // the final triangle wraps the walk back to the top fan
    a_wrap_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && triangle.last |=>
            band_reg == BAND_TOP && slice_reg == '0 && offset_reg == FIRST_RING_OFFSET)
        else $error("walk did not return to start after last triangle");

    // first half of a middle pair keeps the slice and flips the half
    a_pair_half: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !restart && band_reg == BAND_MID && !half_reg |=>
            half_reg && $stable(slice_reg) && $stable(offset_reg))
        else $error("middle pair half sequencing broken");

    // state only moves on a transfer into the result register
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(band_reg) && $stable(slice_reg) && $stable(offset_reg))
        else $error("walker state moved without an advance");
`endif

endmodule

`default_nettype wire

>>> verif/tb_uv_sphere_index_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uv_sphere_index_generator
// Self-checking bench for the uv sphere triangle index generator. A scoreboard
// class walks the sphere alongside the block: it holds its own copy of the
// slice and stack registers and of the walk counters, forms the triangle that
// each input transfer asks for and checks the output transfers in order.
// A directed opening covers the register extremes, two stacks, one slice and
// restart. Random phases follow with changing idle patterns on both sides and
// one long receiver hold-off, then two long walks at the largest sizes.
// ----------------------------------------------------------------------------

module tb_uv_sphere_index_generator;

    import uvs_pkg::*;

    localparam int MAX_SLICES      = 1024;
    localparam int MAX_STACKS      = 1024;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 50000;
    localparam int PRESSURE_HOLD   = 400;
    localparam int RANDOM_PHASES   = 9;
    localparam int PRESSURE_PHASE  = 8;
    localparam int PHASE_ITEMS     = 110;
    localparam int LONG_WALK_ITEMS = 520;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

    localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = 11'h7FF;
    localparam logic [CFG_DATA_W-1:0] CFG_ZERO     = 11'h000;

    class triangle_scoreboard;

        logic [CFG_DATA_W-1:0] slice_reg;
        logic [CFG_DATA_W-1:0] stack_reg;
        band_t                 walk_band;
        logic [9:0]            ring_cnt;
        logic [9:0]            slice_cnt;
        logic                  second_half;
        logic [IDX_W-1:0]      ring_base;
        triangle_t             triangle_q[$];
        int unsigned           failures;

        function new();
            slice_reg = SLICE_COUNT_RESET;
            stack_reg = STACK_COUNT_RESET;
            failures  = 0;
            rewind();
        endfunction

        function void rewind();
            walk_band   = BAND_TOP;
            ring_cnt    = '0;
            slice_cnt   = '0;
            second_half = 1'b0;
            ring_base   = FIRST_RING_OFFSET;
        endfunction

        function int pending();
            return triangle_q.size();
        endfunction

        function void store_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SLICE_COUNT: slice_reg = value;
                REG_STACK_COUNT: stack_reg = value;
                default: ;
            endcase
        endfunction

        // forms the triangle for one accepted request and advances the walk
        function void note_request(logic restart_bit);
            int unsigned s, t, j, off, a, b, c, bottom;
            bit          last_slice;
            triangle_t   shape;
            s = 32'(slice_reg);
            if (s < 1) s = 1;
            else if (s > MAX_SLICES) s = MAX_SLICES;
            t = 32'(stack_reg);
            if (t < 2) t = 2;
            else if (t > MAX_STACKS) t = MAX_STACKS;
            if (restart_bit) rewind();
            j          = 32'(slice_cnt);
            off        = 32'(ring_base);
            last_slice = (j + 1 >= s);
            a = 0;
            b = 0;
            c = 0;
            shape.band = walk_band;
            shape.last = 1'b0;
            case (walk_band)
                BAND_MID:
                begin
                    if (!second_half)
                    begin
                        if (!last_slice)
                        begin
                            a = off + j + s;
                            b = off + j;
                            c = off + j + 1;
                        end
                        else
                        begin
                            a = off + s;
                            b = off + 2 * s - 1;
                            c = off;
                        end
                        second_half = 1'b1;
                    end
                    else
                    begin
                        if (!last_slice)
                        begin
                            a = off + j + s;
                            b = off + j + 1;
                            c = off + j + s + 1;
                            slice_cnt = j[9:0] + 10'd1;
                        end
                        else
                        begin
                            // seam pair closes back to slice 0, then next ring
                            a = off;
                            b = off + 2 * s - 1;
                            c = off + s - 1;
                            slice_cnt = '0;
                            ring_base = off[IDX_W-1:0] + s[IDX_W-1:0];
                            if (ring_cnt + 3 >= t) walk_band = BAND_BOT;
                            else ring_cnt = ring_cnt + 10'd1;
                        end
                        second_half = 1'b0;
                    end
                end
                BAND_BOT:
                begin
                    // bottom pole always follows the current registers
                    bottom = s * (t - 1) + 1;
                    c = bottom;
                    if (!last_slice)
                    begin
                        a = off + j;
                        b = off + j + 1;
                        slice_cnt = j[9:0] + 10'd1;
                    end
                    else
                    begin
                        a = off + s - 1;
                        b = off;
                        shape.last = 1'b1;
                        rewind();
                    end
                end
                default:
                begin
                    shape.band = BAND_TOP;
                    c = 0;
                    if (!last_slice)
                    begin
                        a = j + 2;
                        b = j + 1;
                        slice_cnt = j[9:0] + 10'd1;
                    end
                    else
                    begin
                        a = 1;
                        b = s;
                        slice_cnt   = '0;
                        ring_cnt    = '0;
                        second_half = 1'b0;
                        ring_base   = FIRST_RING_OFFSET;
                        walk_band   = (t == 2) ? BAND_BOT : BAND_MID;
                    end
                end
            endcase
            shape.first  = a[IDX_W-1:0];
            shape.second = b[IDX_W-1:0];
            shape.third  = c[IDX_W-1:0];
            triangle_q = {triangle_q, shape};
        endfunction

        function void check_triangle(logic [IDX_W-1:0] first_idx,
                                     logic [IDX_W-1:0] second_idx,
                                     logic [IDX_W-1:0] third_idx,
                                     logic [1:0]       band_val,
                                     logic             last_val);
            triangle_t want;
            if (triangle_q.size() == 0)
            begin
                $error("triangle transfer with no request waiting");
                failures++;
                return;
            end
            want = triangle_q.pop_front();
            if (first_idx !== want.first)
            begin
                $error("index_first: expected %0d, got %0d", want.first, first_idx);
                failures++;
            end
            if (second_idx !== want.second)
            begin
                $error("index_second: expected %0d, got %0d", want.second, second_idx);
                failures++;
            end
            if (third_idx !== want.third)
            begin
                $error("index_third: expected %0d, got %0d", want.third, third_idx);
                failures++;
            end
            if (band_val !== want.band)
            begin
                $error("band: expected %0d, got %0d", want.band, band_val);
                failures++;
            end
            if (last_val !== want.last)
            begin
                $error("last_triangle: expected %0d, got %0d", want.last, last_val);
                failures++;
            end
        endfunction

    endclass

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic                   restart    = 1'b0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [IDX_W-1:0]       index_first;
    logic [IDX_W-1:0]       index_second;
    logic [IDX_W-1:0]       index_third;
    logic [1:0]             band;
    logic                   last_triangle;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;

    triangle_scoreboard sb;
    int unsigned        sender_idle_pct    = 0;
    int unsigned        receiver_stall_pct = 0;
    logic               pressure_phase     = 1'b0;
    int unsigned        hold_count         = 0;
    int unsigned        cycle_count        = 0;

    uv_sphere_index_generator #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_STACKS (MAX_STACKS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .index_first   (index_first),
        .index_second  (index_second),
        .index_third   (index_third),
        .band          (band),
        .last_triangle (last_triangle),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: checks each output transfer, stalls at random, holds off once
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_triangle(index_first, index_second, index_third, band, last_triangle);
        if (pressure_phase && hold_count < PRESSURE_HOLD)
        begin
            out_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_request(input logic restart_bit);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        do @(posedge clk); while (!in_ready);
        sb.note_request(restart_bit);
    endtask

    // leaves cfg_valid high so that back-to-back writes need no gap
    task automatic program_register(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0]  value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.store_register(idx, value);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] slice_val,
                             input logic [CFG_DATA_W-1:0] stack_val);
        program_register(REG_SLICE_COUNT, slice_val);
        program_register(REG_STACK_COUNT, stack_val);
        cfg_valid <= 1'b0;
    endtask

    // stop requesting, let every triangle out, then give the pipe time to empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned           restart_pct;
        int unsigned           phase;
        logic [CFG_DATA_W-1:0] slice_val;
        logic [CFG_DATA_W-1:0] stack_val;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes, a few steps of the top fan, then restart
        repeat (3) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // spare indexes must be ignored; zero sizes clamp to one slice, two stacks
        program_register(REG_SPARE_LOW, CFG_ALL_ONES);
        program_register(REG_SPARE_HIGH, CFG_ZERO);
        configure(CFG_ZERO, CFG_ZERO);
        repeat (3) send_request(1'b0);
        drain();

        // a small sphere with a middle band (two slices, three stacks), walked once and wrapped
        configure(11'd2, 11'd3);
        send_request(1'b1);
        repeat (8) send_request(1'b0);
        drain();

        // sizes above the maximum clamp
        configure(CFG_ALL_ONES, CFG_ALL_ONES);
        send_request(1'b1);
        repeat (2) send_request(1'b0);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == PRESSURE_PHASE)
            begin
                sender_idle_pct = 0;
                receiver_stall_pct <= 26;
            end
            else
            begin
                case (phase % 4)
                    0:
                    begin
                        sender_idle_pct = 0;
                        receiver_stall_pct <= 0;
                    end
                    1:
                    begin
                        sender_idle_pct = 71;
                        receiver_stall_pct <= 0;
                    end
                    2:
                    begin
                        sender_idle_pct = 0;
                        receiver_stall_pct <= 71;
                    end
                    default:
                    begin
                        sender_idle_pct = 26;
                        receiver_stall_pct <= 26;
                    end
                endcase
            end
            case ($urandom_range(2))
                0:       restart_pct = 0;
                1:       restart_pct = 1;
                default: restart_pct = 4;
            endcase
            // mostly small spheres so that whole walks and wraps happen often
            if ($urandom_range(9) < 7)
            begin
                slice_val = CFG_DATA_W'($urandom_range(12, 1));
                stack_val = CFG_DATA_W'($urandom_range(9, 2));
            end
            else
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        slice_val = CFG_ZERO;
                        stack_val = 11'd1;
                    end
                    1:
                    begin
                        slice_val = CFG_ALL_ONES;
                        stack_val = CFG_DATA_W'($urandom_range(4, 2));
                    end
                    2:
                    begin
                        slice_val = CFG_DATA_W'($urandom_range(3, 1));
                        stack_val = CFG_ALL_ONES;
                    end
                    default:
                    begin
                        slice_val = 11'd1025;
                        stack_val = 11'd1025;
                    end
                endcase
            end
            configure(slice_val, stack_val);
            if (phase == PRESSURE_PHASE) pressure_phase <= 1'b1;
            repeat (PHASE_ITEMS) send_request($urandom_range(99) < restart_pct);
            drain();
            pressure_phase <= 1'b0;
        end

        // long walks at the largest slice count and the largest stack count
        sender_idle_pct = 0;
        receiver_stall_pct <= 0;
        configure(CFG_ALL_ONES, 11'd2);
        send_request(1'b1);
        repeat (LONG_WALK_ITEMS - 1) send_request(1'b0);
        drain();
        configure(11'd1, 11'd1025);
        send_request(1'b1);
        repeat (LONG_WALK_ITEMS - 1) send_request(1'b0);
        drain();

        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
